/* rtl/core/assert_macros.svh */
// Assertion macros shared by the standard-score core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SSN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SSN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SSN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/ssn_pkg.sv */
// Types, codes and constants of the standard-score core.
package ssn_pkg;

  localparam int MAX_FEATURES_DEF = 1024;

  localparam int DVD_W   = 64;
  localparam int DVSR_W  = 24;
  localparam int ITER_W  = 7;
  localparam int ROOT_W  = 32;
  localparam int SQCNT_W = 6;

  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_ACCUM     = 3'd1;
  localparam logic [2:0] OP_FINALIZE  = 3'd2;
  localparam logic [2:0] OP_LOAD_MEAN = 3'd3;
  localparam logic [2:0] OP_LOAD_DEV  = 3'd4;
  localparam logic [2:0] OP_NORMALIZE = 3'd5;

  localparam logic KIND_NORM  = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [9:0]         feature_index;
    logic signed [23:0] value;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [23:0] normalized;
    logic signed [23:0] mean_out;
    logic [22:0]        deviation_out;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_ACC, S_MEAN_GO, S_MEAN_WAIT, S_MSQ_GO,
    S_MSQ_WAIT, S_VAR, S_SQRT_WAIT, S_NORM_GO, S_NORM_WAIT, S_DONE
  } state_t;

endpackage

/* rtl/core/standard_score_normalizer_unit.sv */
// Top level of the standard-score core: feature stores, sequencer, result register.
// Clear and load pass through the read state only, accumulate also through S_ACC;
// normalize runs one divider pass (none at zero deviation); finalize runs two divider
// passes and one root pass. One item is taken at a time, set by the shared bit-serial
// divider and root unit. Reset: synchronous, active low; afterwards the stores are swept
// to zero, one entry a cycle, during which no item beat is taken.
`include "assert_macros.svh"
module standard_score_normalizer_unit #(
  parameter int MAX_FEATURES = ssn_pkg::MAX_FEATURES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssn_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ssn_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
  localparam logic signed [23:0] MIN24 = 24'sh800000;

  // Saturate a 25-bit signed difference to Q8.16.
  function automatic logic signed [23:0] sat25(input logic signed [24:0] d);
    logic signed [23:0] r;
    if (d > 25'sd8388607) begin
      r = MAX24;
    end else if (d < -25'sd8388608) begin
      r = MIN24;
    end else begin
      r = d[23:0];
    end
    return r;
  endfunction

  ssn_pkg::state_t state_r, state_nxt;

  // Feature stores
  logic [39:0]        sum_mem  [MAX_FEATURES];
  logic [63:0]        sq_mem   [MAX_FEATURES];
  logic signed [23:0] mean_mem [MAX_FEATURES];
  logic signed [23:0] dev_mem  [MAX_FEATURES];

  logic [39:0]        rd_sum_r;
  logic [63:0]        rd_sq_r;
  logic signed [23:0] rd_mean_r, rd_dev_r;

  logic               we_sum, we_sq, we_mean, we_dev;
  logic [AW-1:0]      waddr, raddr;
  logic [39:0]        wsum;
  logic [63:0]        wsq;
  logic signed [23:0] wmean, wdev;

  // Working registers
  ssn_pkg::in_item_t  item_r;
  ssn_pkg::out_item_t out_r, res_r;
  logic               out_valid_r;
  logic [15:0]        sample_count_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [47:0]        sq_r, m2_r;
  logic signed [23:0] mean_r;
  logic [63:0]        msq_r;
  logic               neg_r;

  logic                       idx_ok, clr_last, out_free, out_load;
  logic [15:0]                n_eff;
  ssn_pkg::div_req_t          div_req;
  logic                       div_busy;
  logic [ssn_pkg::DVD_W-1:0]  div_q;
  logic                       sqrt_start, sqrt_busy;
  logic [ssn_pkg::DVD_W-1:0]  var_val;
  logic [ssn_pkg::ROOT_W-1:0] root;
  logic [22:0]                dev_clamped;
  logic signed [47:0]         sq_full, m2_full;
  logic signed [24:0]         diff;
  logic [24:0]                diff_mag;
  logic [23:0]                dev_mag;
  logic [39:0]                sum_mag, mean_q;
  logic [40:0]                norm_q;
  logic signed [23:0]         mean_sat, norm_sat;

  assign idx_ok   = {7'd0, item_r.feature_index} < 17'(MAX_FEATURES);
  assign clr_last = (clr_cnt_r == AW'(MAX_FEATURES - 1));
  assign out_free = !out_valid_r || !out_stall;
  assign n_eff    = (sample_count_r == 16'd0) ? 16'd1 : sample_count_r;
  assign raddr    = AW'(item_r.feature_index);

  // Datapath arithmetic
  always_comb begin
    sq_full  = item_r.value * item_r.value;
    m2_full  = mean_r * mean_r;
    sum_mag  = rd_sum_r[39] ? (40'd0 - rd_sum_r) : rd_sum_r;
    diff     = {item_r.value[23], item_r.value} - {rd_mean_r[23], rd_mean_r};
    diff_mag = diff[24] ? (25'd0 - diff) : diff;
    dev_mag  = rd_dev_r[23] ? (24'd0 - rd_dev_r) : rd_dev_r;
    var_val  = (msq_r > {16'd0, m2_r}) ? (msq_r - {16'd0, m2_r}) : 64'd0;
    dev_clamped = (root > 32'd8388607) ? 23'h7FFFFF : root[22:0];

    mean_q = div_q[39:0];
    if (rd_sum_r[39]) begin
      mean_sat = (mean_q > 40'd8388608) ? MIN24 : (24'd0 - mean_q[23:0]);
    end else begin
      mean_sat = (mean_q > 40'd8388607) ? MAX24 : mean_q[23:0];
    end

    norm_q = div_q[40:0];
    if (neg_r) begin
      norm_sat = (norm_q > 41'd8388608) ? MIN24 : (24'd0 - norm_q[23:0]);
    end else begin
      norm_sat = (norm_q > 41'd8388607) ? MAX24 : norm_q[23:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssn_pkg::S_CLEAR:     if (clr_last) state_nxt = ssn_pkg::S_IDLE;
      ssn_pkg::S_IDLE:      if (in_valid) state_nxt = ssn_pkg::S_READ;
      ssn_pkg::S_READ: begin
        state_nxt = ssn_pkg::S_IDLE;
        if (idx_ok) begin
          priority case (item_r.opcode)
            ssn_pkg::OP_ACCUM:     state_nxt = ssn_pkg::S_ACC;
            ssn_pkg::OP_FINALIZE:  state_nxt = ssn_pkg::S_MEAN_GO;
            ssn_pkg::OP_NORMALIZE: state_nxt = ssn_pkg::S_NORM_GO;
            default:               state_nxt = ssn_pkg::S_IDLE;
          endcase
        end
      end
      ssn_pkg::S_ACC:       state_nxt = ssn_pkg::S_IDLE;
      ssn_pkg::S_MEAN_GO:   state_nxt = ssn_pkg::S_MEAN_WAIT;
      ssn_pkg::S_MEAN_WAIT: if (!div_busy) state_nxt = ssn_pkg::S_MSQ_GO;
      ssn_pkg::S_MSQ_GO:    state_nxt = ssn_pkg::S_MSQ_WAIT;
      ssn_pkg::S_MSQ_WAIT:  if (!div_busy) state_nxt = ssn_pkg::S_VAR;
      ssn_pkg::S_VAR:       state_nxt = ssn_pkg::S_SQRT_WAIT;
      ssn_pkg::S_SQRT_WAIT: if (!sqrt_busy) state_nxt = ssn_pkg::S_DONE;
      ssn_pkg::S_NORM_GO: begin
        state_nxt = (rd_dev_r == 24'sd0) ? ssn_pkg::S_DONE : ssn_pkg::S_NORM_WAIT;
      end
      ssn_pkg::S_NORM_WAIT: if (!div_busy) state_nxt = ssn_pkg::S_DONE;
      ssn_pkg::S_DONE:      if (out_free) state_nxt = ssn_pkg::S_IDLE;
      default:              state_nxt = ssn_pkg::S_IDLE;
    endcase
  end

  // Control outputs: store writes, unit launches, result hand-over
  always_comb begin
    we_sum = 1'b0; we_sq = 1'b0; we_mean = 1'b0; we_dev = 1'b0;
    waddr  = raddr;
    wsum   = '0; wsq = '0; wmean = '0; wdev = '0;
    div_req    = '0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ssn_pkg::S_CLEAR: begin
        // Sweep every entry to zero
        waddr  = clr_cnt_r;
        we_sum = 1'b1; we_sq = 1'b1; we_mean = 1'b1; we_dev = 1'b1;
      end
      ssn_pkg::S_READ: begin
        if (idx_ok) begin
          priority case (item_r.opcode)
            ssn_pkg::OP_CLEAR: begin
              we_sum = 1'b1;
              we_sq  = 1'b1;
            end
            ssn_pkg::OP_LOAD_MEAN: begin
              we_mean = 1'b1;
              wmean   = item_r.value;
            end
            ssn_pkg::OP_LOAD_DEV: begin
              we_dev = 1'b1;
              wdev   = item_r.value;
            end
            default: ;
          endcase
        end
      end
      ssn_pkg::S_ACC: begin
        we_sum = 1'b1;
        we_sq  = 1'b1;
        wsum   = rd_sum_r + {{16{item_r.value[23]}}, item_r.value};
        wsq    = rd_sq_r + {16'd0, sq_r};
      end
      ssn_pkg::S_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {sum_mag, 24'd0};
        div_req.divisor  = {8'd0, n_eff};
        div_req.iters    = ssn_pkg::ITER_W'(40);
      end
      ssn_pkg::S_MSQ_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = rd_sq_r;
        div_req.divisor  = {8'd0, n_eff};
        div_req.iters    = ssn_pkg::ITER_W'(64);
      end
      ssn_pkg::S_VAR: sqrt_start = 1'b1;
      ssn_pkg::S_SQRT_WAIT: begin
        if (!sqrt_busy) begin
          we_mean = 1'b1;
          we_dev  = 1'b1;
          wmean   = mean_r;
          wdev    = {1'b0, dev_clamped};
        end
      end
      ssn_pkg::S_NORM_GO: begin
        if (rd_dev_r != 24'sd0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {diff_mag, 39'd0};
          div_req.divisor  = dev_mag;
          div_req.iters    = ssn_pkg::ITER_W'(41);
        end
      end
      ssn_pkg::S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ssn_pkg::S_CLEAR;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      sample_count_r <= 16'd1;
    end else begin
      state_r <= state_nxt;
      if (state_r == ssn_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        sample_count_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: hold the item, the partial results and the result beat
  always_ff @(posedge clk) begin
    if (state_r == ssn_pkg::S_IDLE && in_valid) begin
      item_r <= in_item;
    end
    if (state_r == ssn_pkg::S_READ) begin
      sq_r <= sq_full;
    end
    if (state_r == ssn_pkg::S_MEAN_WAIT && !div_busy) begin
      mean_r <= mean_sat;
    end
    if (state_r == ssn_pkg::S_MSQ_GO) begin
      m2_r <= m2_full;
    end
    if (state_r == ssn_pkg::S_MSQ_WAIT && !div_busy) begin
      msq_r <= div_q;
    end
    if (state_r == ssn_pkg::S_SQRT_WAIT && !sqrt_busy) begin
      res_r.result_kind   <= ssn_pkg::KIND_STATS;
      res_r.normalized    <= '0;
      res_r.mean_out      <= mean_r;
      res_r.deviation_out <= dev_clamped;
    end
    if (state_r == ssn_pkg::S_NORM_GO) begin
      neg_r               <= diff[24] ^ rd_dev_r[23];
      res_r.result_kind   <= ssn_pkg::KIND_NORM;
      res_r.normalized    <= sat25(diff);
      res_r.mean_out      <= '0;
      res_r.deviation_out <= '0;
    end
    if (state_r == ssn_pkg::S_NORM_WAIT && !div_busy) begin
      res_r.normalized <= norm_sat;
    end
    if (out_load) begin
      out_r <= res_r;
    end
  end

  // Store ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (we_sum) sum_mem[waddr] <= wsum;
    rd_sum_r <= sum_mem[raddr];
  end
  always_ff @(posedge clk) begin
    if (we_sq) sq_mem[waddr] <= wsq;
    rd_sq_r <= sq_mem[raddr];
  end
  always_ff @(posedge clk) begin
    if (we_mean) mean_mem[waddr] <= wmean;
    rd_mean_r <= mean_mem[raddr];
  end
  always_ff @(posedge clk) begin
    if (we_dev) dev_mem[waddr] <= wdev;
    rd_dev_r <= dev_mem[raddr];
  end

  ssn_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_q)
  );

  ssn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (var_val),
    .busy     (sqrt_busy),
    .root     (root)
  );

  assign in_stall  = (state_r != ssn_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `SSN_ASSERT_IMPL(a_div_idle_start, clk, rst_n, div_req.start, !div_busy, "divider relaunched while busy")
  `SSN_ASSERT_IMPL(a_sqrt_idle_start, clk, rst_n, sqrt_start, !sqrt_busy, "root unit relaunched while busy")
  `SSN_ASSERT_IMPL(a_no_idle_write, clk, rst_n, state_r == ssn_pkg::S_IDLE, !(we_sum || we_sq || we_mean || we_dev), "store written while idle")
  `SSN_ASSERT_NEXT(a_load_free, clk, rst_n, out_load, out_valid_r && (out_item == $past(res_r)), "result beat not loaded")

endmodule

/* rtl/core/ssn_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module ssn_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssn_pkg::div_req_t         req,
  output logic                      busy,
  output logic [ssn_pkg::DVD_W-1:0] quotient
);

  logic [ssn_pkg::ITER_W-1:0] cnt_r;
  logic [ssn_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [ssn_pkg::DVSR_W-1:0] dvsr_r;
  logic [ssn_pkg::DVSR_W:0]   rem_r, rem_nxt, rem_sh;
  logic                       ge;

  always_comb begin
    rem_sh  = {rem_r[ssn_pkg::DVSR_W-1:0], dvd_r[ssn_pkg::DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvsr_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dvsr_r}) : rem_sh;
    dvd_nxt = {dvd_r[ssn_pkg::DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.iters;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r  <= req.dividend;
      dvsr_r <= req.divisor;
      rem_r  <= '0;
    end else if (busy) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = dvd_r;

endmodule

/* rtl/core/ssn_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
module ssn_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ssn_pkg::DVD_W-1:0]  radicand,
  output logic                       busy,
  output logic [ssn_pkg::ROOT_W-1:0] root
);

  logic [ssn_pkg::SQCNT_W-1:0] cnt_r;
  logic [ssn_pkg::DVD_W-1:0]   rad_r;
  logic [ssn_pkg::ROOT_W-1:0]  root_r;
  logic [ssn_pkg::ROOT_W+1:0]  rem_r, rem_sh, trial, rem_nxt;
  logic                        ge;

  always_comb begin
    rem_sh  = {rem_r[ssn_pkg::ROOT_W-1:0], rad_r[ssn_pkg::DVD_W-1:ssn_pkg::DVD_W-2]};
    trial   = {root_r, 2'b01};
    ge      = rem_sh >= trial;
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= ssn_pkg::SQCNT_W'(ssn_pkg::ROOT_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy) begin
      rad_r  <= {rad_r[ssn_pkg::DVD_W-3:0], 2'b00};
      root_r <= {root_r[ssn_pkg::ROOT_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign root = root_r;

endmodule

/* tb/standard_score_checker.sv */
// Checker for the standard-score unit: predicts results from accepted input beats and compares.
module standard_score_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ssn_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ssn_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0]        sample_n;
  logic [39:0]        sum_mem [1024];
  logic [63:0]        sq_mem  [1024];
  logic signed [23:0] mean_mem[1024];
  logic signed [23:0] dev_mem [1024];
  ssn_pkg::out_item_t expected_q[$];

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic predict_beat(ssn_pkg::in_item_t it);
    ssn_pkg::out_item_t r;
    longint             v, mean, d, q, n;
    logic [63:0]        msq, m2, var_v, dev;
    v = longint'(it.value);
    r = '0;
    case (it.opcode)
      ssn_pkg::OP_CLEAR: begin
        sum_mem[it.feature_index] = '0;
        sq_mem[it.feature_index] = '0;
      end
      ssn_pkg::OP_ACCUM: begin
        sum_mem[it.feature_index] = sum_mem[it.feature_index] + 40'(v);
        sq_mem[it.feature_index] = sq_mem[it.feature_index] + 64'(v * v);
      end
      ssn_pkg::OP_FINALIZE: begin
        n = (sample_n == 0) ? 1 : longint'(sample_n);
        mean = clamp24(longint'($signed(sum_mem[it.feature_index])) / n);
        msq = sq_mem[it.feature_index] / 64'(n);
        m2 = 64'(mean * mean);
        var_v = (msq > m2) ? msq - m2 : 64'd0;
        dev = int_root(var_v);
        if (dev > 64'd8388607) dev = 64'd8388607;
        mean_mem[it.feature_index] = 24'(mean);
        dev_mem[it.feature_index] = 24'(dev);
        r.result_kind = ssn_pkg::KIND_STATS;
        r.mean_out = 24'(mean);
        r.deviation_out = 23'(dev);
        expected_q.push_back(r);
      end
      ssn_pkg::OP_LOAD_MEAN: mean_mem[it.feature_index] = it.value;
      ssn_pkg::OP_LOAD_DEV:  dev_mem[it.feature_index] = it.value;
      ssn_pkg::OP_NORMALIZE: begin
        d = v - longint'(mean_mem[it.feature_index]);
        if (dev_mem[it.feature_index] == 0) q = clamp24(d);
        else q = clamp24((d * 65536) / longint'(dev_mem[it.feature_index]));
        r.result_kind = ssn_pkg::KIND_NORM;
        r.normalized = 24'(q);
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    ssn_pkg::out_item_t e;
    int                 errs;
    errs = 0;
    if (!rst_n) begin
      sample_n <= 16'd1;
      fail_count <= 0;
      pending_count <= 0;
      for (int i = 0; i < 1024; i++) begin
        sum_mem[i] = '0; sq_mem[i] = '0; mean_mem[i] = '0; dev_mem[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (cfg_we) sample_n <= cfg_wdata;
      if (in_valid && !in_stall) predict_beat(in_item);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat %p", out_item);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_item.result_kind !== e.result_kind) begin
            $error("result_kind expected %0d actual %0d", e.result_kind, out_item.result_kind);
            errs++;
          end
          if (out_item.normalized !== e.normalized) begin
            $error("normalized expected %0d actual %0d", e.normalized, out_item.normalized);
            errs++;
          end
          if (out_item.mean_out !== e.mean_out) begin
            $error("mean_out expected %0d actual %0d", e.mean_out, out_item.mean_out);
            errs++;
          end
          if (out_item.deviation_out !== e.deviation_out) begin
            $error("deviation_out expected %0d actual %0d", e.deviation_out,
                   out_item.deviation_out);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending_count <= expected_q.size();
    end
  end
endmodule

/* tb/testbench.sv */
// Top of the standard-score testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ssn_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ssn_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;
  int                 fail_count, pending_count;
  bit                 calm = 1'b0;   // no idling on either side while set

  always #5 clk = ~clk;

  standard_score_normalizer_unit u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item, .cfg_we, .cfg_wdata
  );

  standard_score_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall,
    .out_item, .cfg_we, .cfg_wdata, .fail_count, .pending_count
  );

  // Receiver: unless calm is set, stall with a chance of 35 in a hundred, changed at the falling edge.
  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 35);

  // Present one beat and hold it until accepted; valid is dropped while idling before it.
  task automatic send_beat(logic [2:0] op, logic [9:0] idx, logic [23:0] val);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= '{opcode: op, feature_index: idx, value: val};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for all results and let the unit settle idle before a register write.
  task automatic write_count(logic [15:0] n);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_wdata <= n;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] rand_value();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(511)) - 24'd256;
      default: return 24'($urandom);
    endcase
  endfunction

  // One well-formed pass: clear, accumulate N samples, finalize, normalize up to three times.
  task automatic stats_pass(logic [9:0] idx, int n, bit wide);
    send_beat(ssn_pkg::OP_CLEAR, idx, rand_value());
    for (int i = 0; i < n; i++)
      send_beat(ssn_pkg::OP_ACCUM, idx,
                wide ? rand_value() : 24'($urandom_range(131071)) - 24'd65536);
    send_beat(ssn_pkg::OP_FINALIZE, idx, rand_value());
    repeat ($urandom_range(3)) send_beat(ssn_pkg::OP_NORMALIZE, idx, rand_value());
  endtask

  initial begin
    int n;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, every opcode, zero count, zero and negative deviation, bad opcodes.
    calm = 1'b1;
    send_beat(ssn_pkg::OP_NORMALIZE, 10'd0, 24'h7FFFFF);   // zero deviation, no division
    send_beat(ssn_pkg::OP_NORMALIZE, 10'd1023, 24'h800000);
    send_beat(ssn_pkg::OP_FINALIZE, 10'd5, 24'd0);         // empty sums
    send_beat(ssn_pkg::OP_ACCUM, 10'd7, 24'h800000);
    send_beat(ssn_pkg::OP_ACCUM, 10'd7, 24'h800000);
    send_beat(ssn_pkg::OP_FINALIZE, 10'd7, 24'd0);         // mean saturates
    send_beat(ssn_pkg::OP_ACCUM, 10'd8, 24'h7FFFFF);
    send_beat(ssn_pkg::OP_ACCUM, 10'd8, 24'h800000);
    send_beat(ssn_pkg::OP_FINALIZE, 10'd8, 24'd0);
    send_beat(ssn_pkg::OP_LOAD_MEAN, 10'd9, 24'h800000);
    send_beat(ssn_pkg::OP_LOAD_DEV, 10'd9, 24'd1);
    send_beat(ssn_pkg::OP_NORMALIZE, 10'd9, 24'h7FFFFF);   // quotient saturates
    send_beat(ssn_pkg::OP_LOAD_DEV, 10'd9, 24'hFF0000);    // negative deviation
    send_beat(ssn_pkg::OP_NORMALIZE, 10'd9, 24'h000100);
    send_beat(3'd6, 10'd9, 24'h123456);
    send_beat(3'd7, 10'd9, 24'h654321);
    send_beat(ssn_pkg::OP_CLEAR, 10'd7, 24'd0);
    send_beat(ssn_pkg::OP_NORMALIZE, 10'd9, 24'd0);
    write_count(16'd0);                                     // zero count acts as one
    send_beat(ssn_pkg::OP_FINALIZE, 10'd8, 24'd0);
    write_count(16'hFFFF);
    send_beat(ssn_pkg::OP_FINALIZE, 10'd8, 24'd0);
    // Bring the count back to a small value before the random passes.
    write_count(16'd4);
    calm = 1'b0;
    // Random part: mostly well-formed passes, some noise, several counts.
    n = 0;
    while (n < 950) begin
      if (n > 300 && n < 420) calm = 1'b1; else calm = 1'b0;
      if ($urandom_range(9) == 0) begin
        write_count(16'($urandom_range(1, 6)));
      end
      if ($urandom_range(3) != 0) begin
        stats_pass(10'($urandom), int'(u_chk.sample_n), $urandom_range(1));
        n += int'(u_chk.sample_n) + 3;
      end else begin
        send_beat(3'($urandom), 10'($urandom), rand_value());
        n++;
      end
    end
    write_count(16'd1);
    stats_pass(10'd3, 1, 1'b1);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("PASS standard_score_normalizer_unit");
    else $display("FAIL standard_score_normalizer_unit");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL standard_score_normalizer_unit");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ssn_pkg.sv
rtl/core/ssn_divider.sv
rtl/core/ssn_sqrt.sv
rtl/core/standard_score_normalizer_unit.sv
tb/standard_score_checker.sv
tb/testbench.sv
